@@ rtl/lfs_pkg.sv @@
// lfs_pkg: shared types and constants of the link frame segmenter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

   // Header byte layout
   localparam logic [7:0] HDR_COUNT_MASK = 8'h1F;
   localparam logic [7:0] HDR_FIRST      = 8'h40;
   localparam logic [7:0] HDR_FINAL      = 8'h20;
   localparam int         CNT_W          = 5;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One classified input byte: what the back end has to emit for it
   typedef struct packed {
      logic             has_hdr;   // a frame opens with this byte
      logic [7:0]       hdr;       // header byte when has_hdr
      logic [7:0]       data;      // payload byte
      logic             data_end;  // payload byte closes a full frame
      logic [CNT_W-1:0] pad_n;     // zero bytes after the payload
   } lfs_cmd_type;

endpackage

`default_nettype wire

@@ rtl/lfs_front.sv @@
// lfs_front: accepts input bytes, tracks message/frame position and
// classifies each byte into a command. Depends on lfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfs_front import lfs_pkg::*; #(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  data,
   input  wire logic [15:0] message_length,
   output      logic        push,
   output      lfs_cmd_type cmd
);

   localparam logic [15:0]      FULL_LEN = 16'(FRAME_BYTES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BYTES - 1);

   logic [15:0]      bytes_left_ff, bytes_left_in;
   logic [CNT_W-1:0] frame_pos_ff, frame_pos_in;
   logic             first_frame_ff, first_frame_in;
   logic [CNT_W-1:0] frame_cnt_ff, frame_cnt_in;

   logic             start, drop, open, done, pad;
   logic [15:0]      bl;
   logic             first;
   logic [CNT_W-1:0] pos, cnt, fcount, sent;

   always_comb begin
      start  = (bytes_left_ff == 16'd0);
      drop   = start && (message_length == 16'd0);
      bl     = start ? message_length : bytes_left_ff;
      first  = start ? 1'b1 : first_frame_ff;
      pos    = start ? '0 : frame_pos_ff;
      open   = (pos == '0);
      cnt    = (bl < FULL_LEN) ? bl[CNT_W-1:0] : FULL_CNT;
      fcount = open ? cnt : frame_cnt_ff;
      sent   = open ? CNT_W'(1) : pos;
      done   = (sent >= fcount);
      pad    = done && (fcount < FULL_CNT);

      cmd.has_hdr  = open;
      cmd.hdr      = ({3'b000, cnt} & HDR_COUNT_MASK)
                     | (first ? HDR_FIRST : 8'h00)
                     | ((bl <= FULL_LEN) ? HDR_FINAL : 8'h00);
      cmd.data     = data;
      cmd.data_end = done && !pad;
      cmd.pad_n    = pad ? (FULL_CNT - fcount) : '0;

      push = accept && !drop;

      bytes_left_in  = bl - 16'd1;
      first_frame_in = open ? 1'b0 : first;
      frame_pos_in   = done ? '0 : (sent + CNT_W'(1));
      frame_cnt_in   = fcount;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         frame_pos_ff   <= '0;
         first_frame_ff <= 1'b1;
         frame_cnt_ff   <= '0;
      end else if (push) begin
         bytes_left_ff  <= bytes_left_in;
         frame_pos_ff   <= frame_pos_in;
         first_frame_ff <= first_frame_in;
         frame_cnt_ff   <= frame_cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lfs_queue.sv @@
// lfs_queue: small command FIFO between front and back.
// Depends on lfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfs_queue import lfs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire lfs_cmd_type push_cmd,
   input  wire logic        pop,
   output      logic        full,
   output      logic        not_empty,
   output      lfs_cmd_type head
);

   lfs_cmd_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   always_comb begin
      full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff + (push ? QPTR_W'(1) : '0);
      rd_ptr_in = rd_ptr_ff + (pop ? QPTR_W'(1) : '0);
      count_in  = count_ff + (push ? (QPTR_W+1)'(1) : '0)
                           - (pop ? (QPTR_W+1)'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lfs_back.sv @@
// lfs_back: expands queued commands into header, payload and padding
// bytes behind a registered output stage. Depends on lfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfs_back import lfs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire lfs_cmd_type cmd,
   output      logic        cmd_pop,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_frame_byte,
   output      logic        rsp_is_header,
   output      logic        rsp_frame_end,
   output      logic        rsp_run_last
);

   typedef enum logic [1:0] {
      ST_START,
      ST_DATA,
      ST_PAD
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] pad_left_ff, pad_left_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             hdr_ff, hdr_in;
   logic             end_ff, end_in;
   logic             last_ff, last_in;

   logic load, advance;

   always_comb begin
      load    = !valid_ff || !rsp_stall;
      advance = load && cmd_valid;

      state_in    = state_ff;
      pad_left_in = pad_left_ff;
      cmd_pop     = 1'b0;
      byte_in     = byte_ff;
      hdr_in      = hdr_ff;
      end_in      = end_ff;
      last_in     = last_ff;
      valid_in    = load ? cmd_valid : valid_ff;

      if (advance) begin
         unique case (state_ff)
            ST_START, ST_DATA: begin
               if (state_ff == ST_START && cmd.has_hdr) begin
                  byte_in  = cmd.hdr;
                  hdr_in   = 1'b1;
                  end_in   = 1'b0;
                  last_in  = 1'b0;
                  state_in = ST_DATA;
               end else begin
                  byte_in     = cmd.data;
                  hdr_in      = 1'b0;
                  end_in      = cmd.data_end;
                  last_in     = (cmd.pad_n == '0);
                  pad_left_in = cmd.pad_n;
                  if (cmd.pad_n == '0) begin
                     cmd_pop  = 1'b1;
                     state_in = ST_START;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               byte_in     = 8'h00;
               hdr_in      = 1'b0;
               end_in      = (pad_left_ff == CNT_W'(1));
               last_in     = (pad_left_ff == CNT_W'(1));
               pad_left_in = pad_left_ff - CNT_W'(1);
               if (pad_left_ff == CNT_W'(1)) begin
                  cmd_pop  = 1'b1;
                  state_in = ST_START;
               end
            end
            default: begin
               state_in = ST_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_START;
         pad_left_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pad_left_ff <= pad_left_in;
         valid_ff    <= valid_in;
      end
      byte_ff <= byte_in;
      hdr_ff  <= hdr_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_is_header  = hdr_ff;
   assign rsp_frame_end  = end_ff;
   assign rsp_run_last   = last_ff;

endmodule

`default_nettype wire

@@ rtl/link_frame_segmenter.sv @@
// link_frame_segmenter: top level, splits messages into headed frames.
// Instantiates lfs_front, lfs_queue and lfs_back; depends on lfs_pkg.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------
//   req_     | in        | req_valid/req_stall  | data, message_length
//   rsp_     | out       | rsp_valid/rsp_stall  | frame_byte, is_header,
//            |           |                      | frame_end, run_last
//
// A byte is taken every cycle while the command queue has room; each byte
// turns into 1 + header + padding output transactions, one per cycle while
// rsp_stall is low: one in mid-frame, up to FRAME_BYTES when it opens a
// frame and ends the message short. The back end's one-byte-per-cycle
// output register sets the rate. A request is registered in the queue, then
// in the output register. Reset (synchronous) returns to message start with
// an empty queue. req_stall rises only when the four-entry queue is full.
`timescale 1ns / 1ps
`default_nettype none

module link_frame_segmenter import lfs_pkg::*; #(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data,
   input  wire logic [15:0] req_message_length,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_frame_byte,
   output      logic        rsp_is_header,
   output      logic        rsp_frame_end,
   output      logic        rsp_run_last
);

   logic        q_full, q_not_empty, q_push, q_pop, req_take;
   lfs_cmd_type front_cmd, head_cmd;

   // Stall depends only on queue occupancy, never on req_valid.
   assign req_stall = q_full;
   assign req_take  = req_valid && !q_full;

   // Front: message/frame bookkeeping, one transaction per cycle while the queue is not full.
   lfs_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_take),
      .data           (req_data),
      .message_length (req_message_length),
      .push           (q_push),
      .cmd            (front_cmd)
   );

   // Decouples byte intake from header/padding expansion.
   lfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   // Back: emits header, payload and zero padding in order.
   lfs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_not_empty),
      .cmd            (head_cmd),
      .cmd_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_is_header  (rsp_is_header),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

`default_nettype wire
